/* rtl/rpdm_pkg.sv */
package rpdm_pkg;

  // Device window and error code reported on a failed master response
  localparam int unsigned  WINDOW_SIZE    = 256;
  localparam logic [3:0]   BUS_ERROR_CODE = 4'd1;

  // Register byte offsets
  localparam logic [7:0] OFF_STATUS = 8'h00;
  localparam logic [7:0] OFF_MOVED  = 8'h04;
  localparam logic [7:0] OFF_CTRL   = 8'h08;
  localparam logic [7:0] OFF_SRC    = 8'h0C;
  localparam logic [7:0] OFF_DST    = 8'h10;
  localparam logic [7:0] OFF_LEN    = 8'h14;

  // Bit positions inside register data
  localparam int unsigned STATUS_DONE_BIT = 1;
  localparam int unsigned STATUS_ERR_BIT  = 2;
  localparam int unsigned CTRL_START_BIT  = 8;

  localparam logic [31:0] WORD_BYTES = 32'd4;

  // Decoded-op queue between front and back
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [1:0] {
    CMD_REG_RD  = 2'd0,
    CMD_REG_WR  = 2'd1,
    CMD_RD_RESP = 2'd2,
    CMD_WR_RESP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REG_DATA = 2'd0,
    KIND_RD_REQ   = 2'd1,
    KIND_WR_REQ   = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RD   = 2'd1,
    PH_WR   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    SEL_STATUS,
    SEL_MOVED,
    SEL_CTRL,
    SEL_SRC,
    SEL_DST,
    SEL_LEN,
    SEL_NONE
  } reg_sel_t;

  typedef struct packed {
    cmd_t        cmd;
    reg_sel_t    sel;
    logic [31:0] data;
    logic        ok;
  } op_t;

endpackage

/* rtl/rpdm_if.sv */
interface rpdm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;
  logic        resp_ok;

  modport source (output valid, output cmd, output reg_offset, output write_data,
                  output resp_ok, input ready);
  modport sink (input valid, input cmd, input reg_offset, input write_data,
                input resp_ok, output ready);
endinterface

interface rpdm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] bus_address;
  logic [31:0] out_data;

  modport source (output valid, output kind, output bus_address, output out_data,
                  input ready);
  modport sink (input valid, input kind, input bus_address, input out_data,
                output ready);
endinterface

/* rtl/rpdm_front.sv */
module rpdm_front #(
  parameter int unsigned WINDOW_SIZE = rpdm_pkg::WINDOW_SIZE
) (
  rpdm_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output rpdm_pkg::op_t   q_op
);

  logic               in_window;
  rpdm_pkg::reg_sel_t sel;

  assign in_window = {1'b0, in_ch.reg_offset} < 9'(WINDOW_SIZE);

  always_comb begin
    case (in_ch.reg_offset)
      rpdm_pkg::OFF_STATUS: sel = rpdm_pkg::SEL_STATUS;
      rpdm_pkg::OFF_MOVED:  sel = rpdm_pkg::SEL_MOVED;
      rpdm_pkg::OFF_CTRL:   sel = rpdm_pkg::SEL_CTRL;
      rpdm_pkg::OFF_SRC:    sel = rpdm_pkg::SEL_SRC;
      rpdm_pkg::OFF_DST:    sel = rpdm_pkg::SEL_DST;
      rpdm_pkg::OFF_LEN:    sel = rpdm_pkg::SEL_LEN;
      default:              sel = rpdm_pkg::SEL_NONE;
    endcase
    if (!in_window) begin
      sel = rpdm_pkg::SEL_NONE;
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_op.cmd  = rpdm_pkg::cmd_t'(in_ch.cmd);
    q_op.sel  = sel;
    q_op.data = in_ch.write_data;
    q_op.ok   = in_ch.resp_ok;
  end

endmodule

/* rtl/rpdm_queue.sv */
module rpdm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rpdm_pkg::op_t   push_op,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rpdm_pkg::op_t   head_op
);

  localparam int unsigned AW = rpdm_pkg::QUEUE_AW;

  rpdm_pkg::op_t  mem_r [rpdm_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = count_r == (AW+1)'(rpdm_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* rtl/rpdm_back.sv */
module rpdm_back #(
  parameter logic [3:0] BUS_ERROR_CODE = rpdm_pkg::BUS_ERROR_CODE
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  input  rpdm_pkg::op_t   op,
  output logic            op_pop,
  rpdm_out_if.source      out_ch
);

  // Register file and transfer state
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 err_r, err_nxt;
  logic [3:0]           code_r, code_nxt;
  logic [31:0]          moved_r, moved_nxt;
  logic [1:0]           incr_r, incr_nxt;
  logic [31:0]          src_r, src_nxt;
  logic [31:0]          dst_r, dst_nxt;
  logic [31:0]          len_r, len_nxt;
  logic [31:0]          cur_src_r, cur_src_nxt;
  logic [31:0]          cur_dst_r, cur_dst_nxt;
  logic [32:0]          boff_r, boff_nxt;
  logic [1:0]           lmodes_r, lmodes_nxt;
  logic [31:0]          llen_r, llen_nxt;
  rpdm_pkg::phase_t     phase_r, phase_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  rpdm_pkg::kind_t      out_kind_r, out_kind_nxt;
  logic [31:0]          out_addr_r, out_addr_nxt;
  logic [31:0]          out_data_r, out_data_nxt;

  logic                 res_valid;
  rpdm_pkg::kind_t      res_kind;
  logic [31:0]          res_addr;
  logic [31:0]          res_data;
  logic [31:0]          status_word;
  logic                 go_finish, go_rd, go_wr;
  logic                 in_rd, in_wr;

  assign op_pop      = op_valid && (!out_valid_r || out_ch.ready);
  assign status_word = {24'b0, code_r, 1'b0, err_r, done_r, busy_r};
  assign in_rd       = phase_r == rpdm_pkg::PH_RD;
  assign in_wr       = phase_r == rpdm_pkg::PH_WR;

  // Datapath: register updates and the result each op causes
  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = done_r;
    err_nxt     = err_r;
    code_nxt    = code_r;
    moved_nxt   = moved_r;
    incr_nxt    = incr_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    len_nxt     = len_r;
    cur_src_nxt = cur_src_r;
    cur_dst_nxt = cur_dst_r;
    boff_nxt    = boff_r;
    lmodes_nxt  = lmodes_r;
    llen_nxt    = llen_r;
    res_valid   = 1'b0;
    res_kind    = rpdm_pkg::KIND_REG_DATA;
    res_addr    = '0;
    res_data    = '0;
    go_finish   = 1'b0;
    go_rd       = 1'b0;
    go_wr       = 1'b0;

    if (op_pop) begin
      case (op.cmd)
        rpdm_pkg::CMD_REG_RD: begin
          res_valid = 1'b1;
          case (op.sel)
            rpdm_pkg::SEL_STATUS: res_data = status_word;
            rpdm_pkg::SEL_MOVED:  res_data = moved_r;
            rpdm_pkg::SEL_CTRL:   res_data = {30'b0, incr_r};
            rpdm_pkg::SEL_SRC:    res_data = src_r;
            rpdm_pkg::SEL_DST:    res_data = dst_r;
            rpdm_pkg::SEL_LEN:    res_data = len_r;
            default:              res_data = '0;
          endcase
        end
        rpdm_pkg::CMD_REG_WR: begin
          case (op.sel)
            rpdm_pkg::SEL_STATUS: begin
              if (op.data[rpdm_pkg::STATUS_DONE_BIT]) begin
                done_nxt = 1'b0;
              end
              // clearing the error also clears its code
              if (op.data[rpdm_pkg::STATUS_ERR_BIT]) begin
                err_nxt  = 1'b0;
                code_nxt = '0;
              end
            end
            rpdm_pkg::SEL_CTRL: begin
              incr_nxt = op.data[1:0];
              if (op.data[rpdm_pkg::CTRL_START_BIT] && !busy_r) begin
                err_nxt     = 1'b0;
                done_nxt    = 1'b0;
                moved_nxt   = '0;
                lmodes_nxt  = op.data[1:0];
                llen_nxt    = len_r;
                cur_src_nxt = src_r;
                cur_dst_nxt = dst_r;
                boff_nxt    = '0;
                if (len_r == '0) begin
                  go_finish = 1'b1;
                end else begin
                  busy_nxt  = 1'b1;
                  go_rd     = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = rpdm_pkg::KIND_RD_REQ;
                  res_addr  = src_r;
                end
              end
            end
            rpdm_pkg::SEL_SRC: src_nxt = op.data;
            rpdm_pkg::SEL_DST: dst_nxt = op.data;
            rpdm_pkg::SEL_LEN: len_nxt = op.data;
            default: ;
          endcase
        end
        rpdm_pkg::CMD_RD_RESP: begin
          if (in_rd) begin
            if (!op.ok) begin
              err_nxt   = 1'b1;
              code_nxt  = code_r | BUS_ERROR_CODE;
              go_finish = 1'b1;
            end else begin
              go_wr     = 1'b1;
              res_valid = 1'b1;
              res_kind  = rpdm_pkg::KIND_WR_REQ;
              res_addr  = cur_dst_r;
              res_data  = op.data;
            end
          end
        end
        default: begin
          if (in_wr) begin
            if (!op.ok) begin
              err_nxt   = 1'b1;
              code_nxt  = code_r | BUS_ERROR_CODE;
              go_finish = 1'b1;
            end else begin
              moved_nxt = moved_r + rpdm_pkg::WORD_BYTES;
              boff_nxt  = boff_r + {1'b0, rpdm_pkg::WORD_BYTES};
              if (lmodes_r[0]) begin
                cur_src_nxt = cur_src_r + rpdm_pkg::WORD_BYTES;
              end
              if (lmodes_r[1]) begin
                cur_dst_nxt = cur_dst_r + rpdm_pkg::WORD_BYTES;
              end
              if (boff_nxt < {1'b0, llen_r}) begin
                go_rd     = 1'b1;
                res_valid = 1'b1;
                res_kind  = rpdm_pkg::KIND_RD_REQ;
                res_addr  = cur_src_nxt;
              end else begin
                go_finish = 1'b1;
              end
            end
          end
        end
      endcase

      if (go_finish) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        res_valid = 1'b1;
        res_kind  = rpdm_pkg::KIND_DONE;
        res_addr  = '0;
        res_data  = {24'b0, code_nxt, 1'b0, err_nxt, 1'b1, 1'b0};
      end
    end
  end

  // Phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (go_finish) begin
      phase_nxt = rpdm_pkg::PH_IDLE;
    end else if (go_rd) begin
      phase_nxt = rpdm_pkg::PH_RD;
    end else if (go_wr) begin
      phase_nxt = rpdm_pkg::PH_WR;
    end
  end

  // Result register: loads whenever an op retires, drains on out ready
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    if (op_pop) begin
      out_valid_nxt = res_valid;
      out_kind_nxt  = res_kind;
      out_addr_nxt  = res_addr;
      out_data_nxt  = res_data;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.bus_address = out_addr_r;
  assign out_ch.out_data    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      err_r       <= 1'b0;
      code_r      <= '0;
      moved_r     <= '0;
      incr_r      <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      len_r       <= '0;
      cur_src_r   <= '0;
      cur_dst_r   <= '0;
      boff_r      <= '0;
      lmodes_r    <= '0;
      llen_r      <= '0;
      phase_r     <= rpdm_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      err_r       <= err_nxt;
      code_r      <= code_nxt;
      moved_r     <= moved_nxt;
      incr_r      <= incr_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      len_r       <= len_nxt;
      cur_src_r   <= cur_src_nxt;
      cur_dst_r   <= cur_dst_nxt;
      boff_r      <= boff_nxt;
      lmodes_r    <= lmodes_nxt;
      llen_r      <= llen_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (phase_r != rpdm_pkg::PH_IDLE))
    else $error("busy flag and transfer phase disagree");

  a_offset_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    boff_r[1:0] == 2'b00)
    else $error("transfer byte offset not word aligned");

  a_rd_req_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == rpdm_pkg::KIND_RD_REQ) |-> out_data_r == '0)
    else $error("read request carries data");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == rpdm_pkg::KIND_DONE) |-> !out_data_r[0])
    else $error("finish result reports busy");

endmodule

/* rtl/register_programmed_dma_mover.sv */
// Word-at-a-time DMA engine behind six registers (STATUS, BYTES_MOVED, CTRL,
// SRC, DST, LEN). Items are register reads and writes or master bus responses;
// each produces at most one result: read data, a master read or write request,
// or a transfer-finished report carrying the status. Writing CTRL with bit 8
// set starts a transfer of ceil(LEN/4) words unless one is already running.
// One item is taken per clock: the front decodes the item into a two-entry
// queue, and the back retires one queued op per cycle into a result register
// that is reloaded in the same cycle it is drained. A result is presented by the
// result register after its item has passed through the queue; the back
// stalls only while the result register is full and not being taken, and the
// input stalls only while the queue is full.
module register_programmed_dma_mover #(
  parameter int unsigned WINDOW_SIZE    = rpdm_pkg::WINDOW_SIZE,
  parameter logic [3:0]  BUS_ERROR_CODE = rpdm_pkg::BUS_ERROR_CODE
) (
  input  logic        clk,
  input  logic        rst_n,
  rpdm_in_if.sink     in_ch,
  rpdm_out_if.source  out_ch
);

  logic          q_full;
  logic          q_push;
  rpdm_pkg::op_t q_push_op;
  logic          q_pop;
  logic          q_head_valid;
  rpdm_pkg::op_t q_head_op;

  rpdm_front #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_push_op)
  );

  rpdm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  rpdm_back #(
    .BUS_ERROR_CODE (BUS_ERROR_CODE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_head_valid),
    .op       (q_head_op),
    .op_pop   (q_pop),
    .out_ch   (out_ch)
  );

endmodule

/* test/tb_top.sv */
module tb_top;
  import rpdm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 480;
  localparam int HOLD_OFF       = 300;
  localparam int MAX_PRINTED    = 30;

  localparam logic [7:0]  ST_BUSY      = 8'h01;
  localparam logic [7:0]  ST_DONE      = 8'h01 << STATUS_DONE_BIT;
  localparam logic [7:0]  ST_ERR       = 8'h01 << STATUS_ERR_BIT;
  localparam logic [7:0]  ST_CLEARABLE = ST_DONE | ST_ERR;
  localparam logic [31:0] START        = 32'h1 << CTRL_START_BIT;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] data;
  } dma_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rpdm_in_if  in_ch();
  rpdm_out_if out_ch();

  register_programmed_dma_mover dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the engine state
  logic [7:0]  sh_status  = '0;
  logic [31:0] sh_moved   = '0;
  logic [1:0]  sh_incr    = '0;
  logic [31:0] sh_src     = '0;
  logic [31:0] sh_dst     = '0;
  logic [31:0] sh_len     = '0;
  logic [31:0] sh_cur_src = '0;
  logic [31:0] sh_cur_dst = '0;
  logic [32:0] sh_offset  = '0;
  phase_t      sh_phase   = PH_IDLE;
  logic [1:0]  sh_lmodes  = '0;
  logic [31:0] sh_llen    = '0;

  dma_result_t due_results[$];

  int error_count       = 0;
  int items_accepted    = 0;
  int results_checked   = 0;
  int effective_items   = 0;
  int transfers_started = 0;
  int bus_aborts        = 0;
  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int hold_request      = 0;
  int quiet_cycles      = 0;

  initial forever #5 clk = ~clk;

  function automatic dma_result_t finish_transfer();
    sh_status = (sh_status & ~ST_BUSY) | ST_DONE;
    sh_phase  = PH_IDLE;
    return '{kind: KIND_DONE, addr: 32'h0, data: {24'h0, sh_status}};
  endfunction

  function automatic dma_result_t abort_transfer();
    sh_status = sh_status | ST_ERR | {BUS_ERROR_CODE, 4'h0};
    bus_aborts++;
    return finish_transfer();
  endfunction

  // Advances the shadow state by one item; returns 1 when the item yields a result.
  function automatic bit dma_next_result(input cmd_t c, input logic [7:0] off,
                                         input logic [31:0] d, input logic ok,
                                         output dma_result_t r);
    logic [7:0] clr;
    r = '{kind: KIND_REG_DATA, addr: 32'h0, data: 32'h0};
    case (c)
      CMD_REG_RD: begin
        case (off)
          OFF_STATUS: r.data = {24'h0, sh_status};
          OFF_MOVED:  r.data = sh_moved;
          OFF_CTRL:   r.data = {30'h0, sh_incr};
          OFF_SRC:    r.data = sh_src;
          OFF_DST:    r.data = sh_dst;
          OFF_LEN:    r.data = sh_len;
          default:    r.data = 32'h0;
        endcase
        return 1'b1;
      end
      CMD_REG_WR: begin
        case (off)
          OFF_STATUS: begin
            clr = d[7:0] & ST_CLEARABLE;
            sh_status = sh_status & ~clr;
            // clearing the error flag drops the error code too
            if ((clr & ST_ERR) != 0) sh_status = sh_status & 8'h0F;
          end
          OFF_CTRL: begin
            sh_incr = d[1:0];
            if (d[CTRL_START_BIT] && (sh_status & ST_BUSY) == 0) begin
              sh_status  = (sh_status & ~ST_CLEARABLE) | ST_BUSY;
              sh_moved   = '0;
              sh_lmodes  = sh_incr;
              sh_llen    = sh_len;
              sh_cur_src = sh_src;
              sh_cur_dst = sh_dst;
              sh_offset  = '0;
              transfers_started++;
              if (sh_llen == 0) begin
                r = finish_transfer();
                return 1'b1;
              end
              sh_phase = PH_RD;
              r = '{kind: KIND_RD_REQ, addr: sh_cur_src, data: 32'h0};
              return 1'b1;
            end
          end
          OFF_SRC: sh_src = d;
          OFF_DST: sh_dst = d;
          OFF_LEN: sh_len = d;
          default: ;
        endcase
        return 1'b0;
      end
      CMD_RD_RESP: begin
        if (sh_phase != PH_RD) return 1'b0;
        if (!ok) begin
          r = abort_transfer();
          return 1'b1;
        end
        sh_phase = PH_WR;
        r = '{kind: KIND_WR_REQ, addr: sh_cur_dst, data: d};
        return 1'b1;
      end
      default: begin
        if (sh_phase != PH_WR) return 1'b0;
        if (!ok) begin
          r = abort_transfer();
          return 1'b1;
        end
        sh_moved  = sh_moved + WORD_BYTES;
        sh_offset = sh_offset + {1'b0, WORD_BYTES};
        if (sh_lmodes[0]) sh_cur_src = sh_cur_src + WORD_BYTES;
        if (sh_lmodes[1]) sh_cur_dst = sh_cur_dst + WORD_BYTES;
        if (sh_offset < {1'b0, sh_llen}) begin
          sh_phase = PH_RD;
          r = '{kind: KIND_RD_REQ, addr: sh_cur_src, data: 32'h0};
          return 1'b1;
        end
        r = finish_transfer();
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // prediction on the input side, checking on the output side, watchdog
  always @(posedge clk) begin
    dma_result_t want;
    bit          has;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        items_accepted++;
        has = dma_next_result(cmd_t'(in_ch.cmd), in_ch.reg_offset, in_ch.write_data,
                              in_ch.resp_ok, want);
        if (has) due_results.push_back(want);
        if (has || (cmd_t'(in_ch.cmd) == CMD_REG_WR &&
                    in_ch.reg_offset inside {OFF_STATUS, OFF_CTRL, OFF_SRC, OFF_DST, OFF_LEN}))
          effective_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0d addr %h data %h",
                                    out_ch.kind, out_ch.bus_address, out_ch.out_data));
        end else begin
          want = due_results.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch($sformatf("kind: got %0d, want %0d", out_ch.kind, want.kind));
          if (out_ch.bus_address !== want.addr)
            report_mismatch($sformatf("bus_address: got %h, want %h",
                                      out_ch.bus_address, want.addr));
          if (out_ch.out_data !== want.data)
            report_mismatch($sformatf("out_data: got %h, want %h", out_ch.out_data, want.data));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // result receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input cmd_t c, input logic [7:0] off, input logic [31:0] d,
                           input logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.reg_offset <= off;
    in_ch.write_data <= d;
    in_ch.resp_ok    <= ok;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic host_read(input logic [7:0] off);
    send_item(CMD_REG_RD, off, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic host_write(input logic [7:0] off, input logic [31:0] d);
    send_item(CMD_REG_WR, off, d, 1'($urandom_range(1)));
  endtask

  task automatic bus_reply(input cmd_t c, input logic [31:0] d, input logic ok);
    send_item(c, 8'($urandom_range(255)), d, ok);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    if ($urandom_range(7) == 0) return 32'hFFFF_FFF0 + $urandom_range(15);
    return $urandom;
  endfunction

  task automatic noise_item();
    logic [7:0] off;
    case ($urandom_range(5))
      0:       off = OFF_STATUS;
      1:       off = OFF_MOVED;
      2:       off = OFF_CTRL;
      3:       off = OFF_LEN;
      default: off = 8'($urandom_range(255));
    endcase
    send_item(cmd_t'($urandom_range(3)), off, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic run_random_transfer();
    logic [31:0] len;
    int          words;
    case ($urandom_range(19))
      0, 1:       len = $urandom;              // cut short by a bus error below
      2, 3, 4, 5: len = $urandom_range(25, 64);
      default:    len = $urandom_range(0, 24);
    endcase
    host_write(OFF_SRC, pick_address());
    host_write(OFF_DST, pick_address());
    host_write(OFF_LEN, len);
    host_write(OFF_CTRL, $urandom | START);
    words = 0;
    while (sh_phase != PH_IDLE) begin
      if ($urandom_range(11) == 0) begin
        noise_item();
      end else if (sh_phase == PH_RD) begin
        bus_reply(CMD_RD_RESP, $urandom, $urandom_range(39) != 0);
      end else begin
        words++;
        bus_reply(CMD_WR_RESP, $urandom, words < 24 && $urandom_range(39) != 0);
      end
    end
    if ($urandom_range(1)) host_read(OFF_STATUS);
    if ($urandom_range(1)) host_read(OFF_MOVED);
  endtask

  task automatic test_register_access();
    host_read(OFF_STATUS);
    host_write(OFF_SRC, 32'hFFFF_FFFC);
    host_write(OFF_DST, 32'h0);
    host_write(OFF_LEN, 32'd5);
    host_write(OFF_MOVED, 32'hFFFF_FFFF);  // read only
    host_write(8'h19, 32'hFFFF_FFFF);      // unaligned offset
    host_read(8'h19);
    host_read(8'hFF);
    host_read(OFF_SRC);
  endtask

  task automatic test_directed_transfers();
    host_write(OFF_CTRL, START | 32'h3);   // source wraps past zero on the second word
    host_write(OFF_CTRL, START);           // ignored while busy
    bus_reply(CMD_WR_RESP, 32'h0, 1'b1);   // wrong phase
    bus_reply(CMD_RD_RESP, 32'hFFFF_FFFF, 1'b1);
    bus_reply(CMD_WR_RESP, 32'h0, 1'b1);
    bus_reply(CMD_RD_RESP, 32'h0, 1'b1);
    bus_reply(CMD_WR_RESP, 32'h0, 1'b1);   // partial last word ends it
    host_read(OFF_MOVED);
    host_write(OFF_CTRL, START);
    bus_reply(CMD_RD_RESP, 32'h1234_5678, 1'b0);
    host_read(OFF_STATUS);
    host_write(OFF_STATUS, {24'h0, ST_DONE});
    host_write(OFF_LEN, 32'h0);
    host_write(OFF_CTRL, 32'hFFFF_FFFF);   // zero length, error code must survive
    host_write(OFF_STATUS, 32'hFFFF_FFFF);
    host_read(OFF_STATUS);
    host_write(OFF_LEN, 32'd4);
    host_write(OFF_CTRL, START);
    bus_reply(CMD_RD_RESP, 32'hA5A5_5A5A, 1'b1);
    bus_reply(CMD_WR_RESP, 32'h0, 1'b0);
    host_read(OFF_CTRL);
    wait_results_drained();
  endtask

  task automatic test_random_transfers();
    int first;
    int quarter;
    first   = effective_items;
    quarter = RANDOM_ITEMS / 4;
    while (effective_items < first + RANDOM_ITEMS) begin
      case ((effective_items - first) / quarter)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if ($urandom_range(9) < 2) noise_item();
      else run_random_transfer();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    hold_request = HOLD_OFF;
    // reads pile up behind the held output until the input stalls
    repeat (16) host_read(OFF_MOVED);
    wait_results_drained();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cmd        = '0;
    in_ch.reg_offset = '0;
    in_ch.write_data = '0;
    in_ch.resp_ok    = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed_transfers();
    test_random_transfers();
    test_backpressure();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run summary: %0d items in, %0d results checked, %0d transfers started,",
             items_accepted, results_checked, transfers_started);
    $display("  %0d ended by bus error, plus register access and a held-off output stretch.",
             bus_aborts);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
